// ===== rtl/mexp_pkg.sv =====
// Package with shared constants and types for the modular exponentiation block.
package mexp_pkg;

  localparam int DATA_W   = 64;
  localparam int MOD_W    = 31;
  localparam int EXP_BITS = 64;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 3;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd998244353;

  // Only the low EXP_BITS bits of the exponent magnitude are scanned.
  localparam logic [DATA_W-1:0] EXP_MASK =
      (EXP_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << EXP_BITS) - 64'd1);

  // Steps of the shared shift-add-reduce unit.
  localparam logic [CNT_W-1:0] RED_STEPS = CNT_W'(DATA_W);
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MOD_W);

  // Register index of the modulus, taken from the word address.
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RED   = 6'b000010,
    S_ROUND = 6'b000100,
    S_MULA  = 6'b001000,
    S_SQR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ===== rtl/modular_exponentiation_top.sv =====
// Modular exponentiation top level: sequencer around one shift-add-reduce unit.
// After a request is taken the unit first reduces the base, then squares once per scanned
// exponent bit and multiplies first on each set bit, up to 64 bits; a negative exponent
// adds up to 31 such rounds for modulus-2 before the result is closed out.
// One request is in flight at a time, set by the single unit.
// Reset is synchronous (rst_n low): the sequencer idles, modulus is 998244353.
module modular_exponentiation_top
  import mexp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_base,
  input  logic signed [DATA_W-1:0] in_exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [MOD_W-1:0]  out_power,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic        [ADDR_W-1:0] cfg_paddr,
  input  logic        [31:0]       cfg_pwdata,
  output logic        [31:0]       cfg_prdata,
  output logic                     cfg_pready
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  opnd_r, opnd_nxt;
  logic [MOD_W-1:0]   mula_r, mula_nxt;
  logic [MOD_W-1:0]   red_r, red_nxt;
  logic [MOD_W-1:0]   acc_r, acc_nxt;
  logic [MOD_W-1:0]   b_r, b_nxt;
  logic [DATA_W-1:0]  e_r, e_nxt;
  logic               bneg_r, bneg_nxt;
  logic               eneg_r, eneg_nxt;
  logic               phase2_r, phase2_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0]   out_power_r, out_power_nxt;
  logic [MOD_W-1:0]   modulus_r, modulus_nxt;

  logic [DATA_W-1:0]  base_u, exp_u, bmag, emag;
  logic [MOD_W:0]     mod_ext, dbl, dbl_red, sum, sum_red;
  logic [MOD_W-1:0]   step_res;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODULUS) ? {1'b0, modulus_r} : 32'd0;

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_wr && cfg_paddr[2] == REG_MODULUS) begin
      modulus_nxt = cfg_pwdata[MOD_W-1:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  assign base_u = in_base;
  assign exp_u  = in_exponent;
  assign bmag   = base_u[DATA_W-1] ? (DATA_W'(0) - base_u) : base_u;
  assign emag   = exp_u[DATA_W-1] ? (DATA_W'(0) - exp_u) : exp_u;

  // One step: double the partial remainder, add the addend when the operand's
  // top bit is set, and keep the result below the modulus.
  assign mod_ext  = {1'b0, modulus_r};
  assign dbl      = {red_r, 1'b0};
  assign dbl_red  = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
  assign sum      = dbl_red + (opnd_r[DATA_W-1] ? {1'b0, mula_r} : '0);
  assign sum_red  = (sum >= mod_ext) ? (sum - mod_ext) : sum;
  assign step_res = sum_red[MOD_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    opnd_nxt      = opnd_r;
    mula_nxt      = mula_r;
    red_nxt       = red_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    bneg_nxt      = bneg_r;
    eneg_nxt      = eneg_r;
    phase2_nxt    = phase2_r;
    out_valid_nxt = out_valid_r;
    out_power_nxt = out_power_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cnt_r != '0) begin
      red_nxt  = step_res;
      opnd_nxt = opnd_r << 1;
      cnt_nxt  = cnt_r - 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bneg_nxt   = base_u[DATA_W-1];
          eneg_nxt   = exp_u[DATA_W-1];
          phase2_nxt = 1'b0;
          e_nxt      = emag & EXP_MASK;
          opnd_nxt   = bmag;
          mula_nxt   = MOD_W'(1);
          red_nxt    = '0;
          if (modulus_r < MOD_W'(2)) begin
            // No valid residue exists, so the result is zero.
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt   = RED_STEPS;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (cnt_r == '0) begin
          b_nxt     = (bneg_r && red_r != '0) ? (modulus_r - red_r) : red_r;
          acc_nxt   = MOD_W'(1);
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (e_r == '0) begin
          if (eneg_r && !phase2_r && acc_r != '0) begin
            // Fermat inverse: raise the first result to modulus-2.
            phase2_nxt = 1'b1;
            b_nxt      = acc_r;
            acc_nxt    = MOD_W'(1);
            e_nxt      = DATA_W'(modulus_r - MOD_W'(2));
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          mula_nxt  = e_r[0] ? acc_r : b_r;
          opnd_nxt  = {b_r, {(DATA_W-MOD_W){1'b0}}};
          red_nxt   = '0;
          cnt_nxt   = MUL_STEPS;
          state_nxt = e_r[0] ? S_MULA : S_SQR;
        end
      end
      S_MULA: begin
        if (cnt_r == '0) begin
          acc_nxt   = red_r;
          mula_nxt  = b_r;
          opnd_nxt  = {b_r, {(DATA_W-MOD_W){1'b0}}};
          red_nxt   = '0;
          cnt_nxt   = MUL_STEPS;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (cnt_r == '0) begin
          b_nxt     = red_r;
          e_nxt     = e_r >> 1;
          state_nxt = S_ROUND;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase2_r    <= 1'b0;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase2_r    <= phase2_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r      <= opnd_nxt;
    mula_r      <= mula_nxt;
    red_r       <= red_nxt;
    acc_r       <= acc_nxt;
    b_r         <= b_nxt;
    e_r         <= e_nxt;
    bneg_r      <= bneg_nxt;
    eneg_r      <= eneg_nxt;
    out_power_r <= out_power_nxt;
  end

endmodule

// ===== test/mexp_power_checker.sv =====
`timescale 1ns / 1ps
// Checker for the modular exponentiation block: predicts each power and compares results.
module mexp_power_checker
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DATA_W-1:0] in_base,
  input  logic [DATA_W-1:0] in_exponent,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [MOD_W-1:0]  out_power,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [MOD_W-1:0]  power;
  } power_due_t;

  power_due_t       powers_due[$];
  power_due_t       due;
  logic [MOD_W-1:0] modulus_q;
  int               bad_count = 0;

  // Right-to-left scan: multiply on set bits, square on every bit.
  function automatic longint unsigned square_multiply(longint unsigned b, longint unsigned e,
                                                      int bits, longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    for (int i = 0; i < bits && i < 64; i++) begin
      if (((e >> i) & 64'd1) != 0) acc = (acc * b) % m;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  function automatic logic [MOD_W-1:0] predict_power(logic [DATA_W-1:0] base_raw,
                                                     logic [DATA_W-1:0] exp_raw,
                                                     logic [MOD_W-1:0] modulus);
    longint unsigned m;
    longint unsigned mag;
    longint unsigned b;
    longint unsigned e;
    longint unsigned r;
    m = longint'(modulus);
    if (m < 2) return '0;
    mag = base_raw[DATA_W-1] ? 64'd0 - base_raw : base_raw;
    b = mag % m;
    if (base_raw[DATA_W-1] && b != 0) b = m - b;
    e = exp_raw[DATA_W-1] ? 64'd0 - exp_raw : exp_raw;
    r = square_multiply(b, e, EXP_BITS, m);
    // A negative exponent inverts through Fermat; a zero power has no inverse and stays zero.
    if (exp_raw[DATA_W-1] && r != 0) r = square_multiply(r, m - 2, 32, m);
    return r[MOD_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q = MODULUS_RESET;
      powers_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[ADDR_W-1:2] == REG_MODULUS)
        modulus_q = cfg_pwdata[MOD_W-1:0];
      if (in_valid && !in_stall) begin
        due.base = in_base;
        due.exponent = in_exponent;
        due.power = predict_power(in_base, in_exponent, modulus_q);
        powers_due.insert(powers_due.size(), due);
      end
      if (out_valid && !out_stall) begin
        if (powers_due.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected power %0d with no request outstanding", out_power);
          bad_count++;
        end else begin
          due = powers_due.pop_front();
          if (out_power !== due.power) begin
            if (bad_count < 10)
              $display("power mismatch: base %h exponent %h expected %0d actual %0d",
                       due.base, due.exponent, due.power, out_power);
            bad_count++;
          end
        end
      end
    end
    pending <= powers_due.size();
    fail_count <= bad_count;
  end

endmodule

// ===== test/modular_exponentiation_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the modular exponentiation block: stimulus, receiver stalls and verdict.
module modular_exponentiation_top_test;
  import mexp_pkg::*;

  localparam int IDLE_LIMIT   = 30000;
  localparam int DRAIN_CYCLES = 6500;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 30;
  localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'({REG_MODULUS, 2'b00});

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [DATA_W-1:0] in_base;
  logic [DATA_W-1:0] in_exponent;
  logic out_valid;
  logic out_stall;
  logic [MOD_W-1:0] out_power;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int fail_count;
  int pending;
  int powers_taken = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  modular_exponentiation_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_base(in_base), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall), .out_power(out_power),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  mexp_power_checker power_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_base(in_base), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall), .out_power(out_power),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (out_valid && !out_stall) powers_taken <= powers_taken + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: short and long stalls, free-running stretches, and one long hold-off
  // while requests keep arriving.
  initial begin
    int pick;
    int len;
    logic hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && powers_taken >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 40);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(30, 150);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic int request_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) burst_left = $urandom_range(10, 30);
    if (pick < 40) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 120);
  endfunction

  // Called in the step of the previous acceptance; in_valid gets one assignment per step.
  task automatic send_request(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] e);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base <= b;
    in_exponent <= e;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input logic [31:0] m);
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] mag;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b = {$urandom, $urandom};
    end else begin
      if (pick < 85) b = 64'($urandom_range(0, 1000));
      else b = 64'($urandom_range(0, 1000)) * 64'(m) + 64'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) b = 64'd0 - b;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) mag = 64'($urandom_range(0, 300));
    else if (pick < 85) mag = 64'($urandom_range(0, 1 << 20));
    else if (pick < 95) mag = {$urandom, $urandom};
    else begin
      case ($urandom_range(0, 3))
        0: mag = 64'd0;
        1: mag = 64'h8000_0000_0000_0000;
        2: mag = 64'h7fff_ffff_ffff_ffff;
        default: mag = 64'd1;
      endcase
    end
    send_request(b, ($urandom_range(0, 9) < 4) ? 64'd0 - mag : mag);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Set the modulus while the block is idle, then run random requests under it.
  task automatic run_phase(input logic [31:0] m, input int count);
    cfg_write(MODULUS_ADDR, m);
    repeat (count) send_random(m);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_base <= '0;
    in_exponent <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset modulus.
    send_request(64'd0, 64'd0);
    send_request(64'd5, 64'd0);
    send_request(64'd2, 64'd10);
    send_request(64'h8000_0000_0000_0000, 64'd3);
    send_request(64'h7fff_ffff_ffff_ffff, 64'd5);
    send_request(64'hffff_ffff_ffff_ffff, 64'd3);
    send_request(64'd0 - 64'd998244353, 64'd2);
    send_request(64'd998244353, 64'd1);
    send_request(64'd0, 64'hffff_ffff_ffff_ffff);
    send_request(64'd3, 64'hffff_ffff_ffff_ffff);
    send_request(64'd7, 64'd0 - 64'd5);
    send_request(64'd0 - 64'd7, 64'd0 - 64'd3);
    send_request(64'd2, 64'h8000_0000_0000_0000);
    send_request(64'd3, 64'h7fff_ffff_ffff_ffff);
    send_request(64'd12345, 64'd1);
    repeat (300) send_random(32'd998244353);
    in_valid <= 1'b0;
    wait_drained();

    run_phase(32'd2147483647, 250);
    run_phase(32'd2, 100);
    run_phase(32'd3, 100);
    run_phase(32'd1000000007, 250);
    // Composite modulus: a negative exponent still raises to modulus minus two.
    run_phase(32'd1000, 100);
    run_phase(32'd97, 100);
    // Moduli below two leave no valid residue.
    run_phase(32'd1, 20);
    run_phase(32'd0, 20);
    run_phase(32'd998244353, 100);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
